// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SUST_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sust check failed");

// plain invariant checked on every rising clock edge outside reset
`define SUST_INVARIANT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("sust invariant failed");

`endif

// ===== hw/rtl/sust_pkg.sv =====
package sust_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2
  } cell_op_t;

  typedef logic [VALUE_BITS-1:0] elem_t;

  typedef struct packed {
    cell_op_t op;
    elem_t    key;
  } cell_ctrl_t;

  // low VALUE_BITS bits of the word sign-extended from bit 31
  function automatic elem_t to_elem(input logic [31:0] v);
    logic [63:0] w;
    w = {{32{v[31]}}, v};
    return w[VALUE_BITS-1:0];
  endfunction

endpackage

// ===== hw/rtl/sorted_unique_set_table_top.sv =====
// sorted unique set table
// keeps up to CAPACITY distinct signed values in ascending order in a row
// of cells; every cell compares its entry with the command value at once
// and takes its own, a neighbor's entry or the command value on update
// in channel: in_tuser carries the command (insert, erase, find, clear),
// in_tdata the value; one word in gives exactly one result word
// out channel: out_tdata carries status, present, rank and element count
// latency: the result is valid in the cycle after the word is accepted
// throughput: one command per cycle, set by the single compare and shift
// step of the cell row; the next command sees the updated set at once
// reset (synchronous, rst_n low) empties the set and drops a pending result
// while the receiver stalls the result is held in the output register and
// in_tready stays low until it is taken
`include "assert_macros.svh"

module sorted_unique_set_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] status, [2] present, [7:3] rank,
                                  // [12:8] element_count, [15:13] zero
);

  localparam int CAP   = sust_pkg::CAPACITY;
  localparam int CNT_W = sust_pkg::CNT_W;
  localparam int IDX_W = sust_pkg::IDX_W;

  logic [CNT_W-1:0]     held_cnt_r;
  logic [CNT_W-1:0]     held_cnt_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [15:0]          out_data_r;
  logic [15:0]          out_data_nxt;
  logic                 accept;
  sust_pkg::cmd_t       cmd;
  sust_pkg::cell_ctrl_t ctrl;
  sust_pkg::elem_t      q_vec [CAP];
  logic [CAP-1:0]       lt_vec;
  logic [CAP-1:0]       eq_vec;
  logic [CAP-1:0]       occ_vec;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic [CNT_W-1:0]     rank;
  logic                 full;
  sust_pkg::status_t    status;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cmd       = sust_pkg::cmd_t'(in_tuser);
  assign full      = (held_cnt_r >= CNT_W'(CAP));

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAP; i++) begin
      occ_vec[i] = (CNT_W'(i) < held_cnt_r);
      if (eq_vec[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign hit  = |eq_vec;
  assign rank = hit ? CNT_W'(hit_idx) : held_cnt_r;

  always_comb begin
    ctrl.key     = sust_pkg::to_elem(in_tdata);
    ctrl.op      = sust_pkg::OP_HOLD;
    held_cnt_nxt = held_cnt_r;
    status       = sust_pkg::ST_DONE;
    unique case (cmd)
      sust_pkg::CMD_INSERT: begin
        if (hit) begin
          status = sust_pkg::ST_FOUND;
        end else if (full) begin
          status = sust_pkg::ST_FULL;
        end else begin
          status = sust_pkg::ST_DONE;
          if (accept) begin
            ctrl.op      = sust_pkg::OP_INSERT;
            held_cnt_nxt = held_cnt_r + CNT_W'(1);
          end
        end
      end
      sust_pkg::CMD_ERASE: begin
        if (hit) begin
          status = sust_pkg::ST_DONE;
          if (accept) begin
            ctrl.op      = sust_pkg::OP_ERASE;
            held_cnt_nxt = held_cnt_r - CNT_W'(1);
          end
        end else begin
          status = sust_pkg::ST_NOT_FOUND;
        end
      end
      sust_pkg::CMD_FIND: begin
        status = hit ? sust_pkg::ST_FOUND : sust_pkg::ST_NOT_FOUND;
      end
      sust_pkg::CMD_CLEAR: begin
        status = sust_pkg::ST_DONE;
        if (accept) begin
          held_cnt_nxt = '0;
        end
      end
      default: status = sust_pkg::ST_DONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'b000, 5'(held_cnt_nxt), 5'(rank), hit, status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_cnt_r  <= held_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic            left_lt;
    sust_pkg::elem_t left_q;
    sust_pkg::elem_t right_q;

    if (i == 0) begin : g_first
      assign left_lt = 1'b1;
      assign left_q  = ctrl.key;
    end else begin : g_mid
      assign left_lt = lt_vec[i-1];
      assign left_q  = q_vec[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign right_q = q_vec[i];
    end else begin : g_inner
      assign right_q = q_vec[i+1];
    end

    sust_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .occ     (occ_vec[i]),
      .left_lt (left_lt),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (q_vec[i]),
      .lt      (lt_vec[i]),
      .eq      (eq_vec[i])
    );
  end

  `SUST_INVARIANT(a_cnt_bound, held_cnt_r <= CNT_W'(CAP))
  `SUST_INVARIANT(a_single_hit, $onehot0(eq_vec))
  `SUST_ASSERT(a_result_follows, accept |=> out_valid_r)
  `SUST_ASSERT(a_clear_empties, (accept && cmd == sust_pkg::CMD_CLEAR) |=> (held_cnt_r == '0))

endmodule

// ===== hw/rtl/sust_cell.sv =====
module sust_cell (
  input  logic                 clk,
  input  sust_pkg::cell_ctrl_t ctrl,
  input  logic                 occ,
  input  logic                 left_lt,
  input  sust_pkg::elem_t      left_q,
  input  sust_pkg::elem_t      right_q,
  output sust_pkg::elem_t      q,
  output logic                 lt,
  output logic                 eq
);

  sust_pkg::elem_t q_r;
  sust_pkg::elem_t q_nxt;

  assign lt = occ && ($signed(q_r) < $signed(ctrl.key));
  assign eq = occ && (q_r == ctrl.key);
  assign q  = q_r;

  always_comb begin
    q_nxt = q_r;
    case (ctrl.op)
      sust_pkg::OP_INSERT: begin
        if (!lt) begin
          q_nxt = left_lt ? ctrl.key : left_q;
        end
      end
      sust_pkg::OP_ERASE: begin
        if (!lt) begin
          q_nxt = right_q;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

// ===== tb/sorted_unique_set_table_top_tb.sv =====
`timescale 1ns / 100ps

module sorted_unique_set_table_top_tb;

  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    sust_pkg::status_t status;
    logic              present;
    logic [4:0]        rank;
    logic [4:0]        count;
  } set_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  // model of the table contents, in ascending order
  logic signed [31:0] held_vals [sust_pkg::CAPACITY];
  int                 held_n = 0;
  set_result_t        pending_results[$];
  int                 mismatch_count = 0;
  bit                 no_idle = 1'b0;
  logic [31:0]        value_pool [32];
  int                 pool_n = 1;

  sorted_unique_set_table_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  function automatic void apply_command(input sust_pkg::cmd_t cmd,
                                        input logic [31:0] raw);
    logic signed [31:0] v;
    int                 pos;
    int                 cnt;
    int                 i;
    bit                 hit;
    set_result_t        r;
    v   = raw;
    cnt = held_n;
    pos = 0;
    while (pos < cnt && held_vals[pos] < v) pos++;
    hit       = (pos < cnt) && (held_vals[pos] == v);
    r.present = hit;
    r.rank    = hit ? 5'(pos) : 5'(cnt);
    case (cmd)
      sust_pkg::CMD_INSERT: begin
        if (hit) begin
          r.status = sust_pkg::ST_FOUND;
        end else if (cnt >= sust_pkg::CAPACITY) begin
          r.status = sust_pkg::ST_FULL;
        end else begin
          for (i = cnt; i > pos; i--) held_vals[i] = held_vals[i-1];
          held_vals[pos] = v;
          cnt++;
          r.status = sust_pkg::ST_DONE;
        end
      end
      sust_pkg::CMD_ERASE: begin
        if (hit) begin
          for (i = pos; i + 1 < cnt; i++) held_vals[i] = held_vals[i+1];
          cnt--;
          r.status = sust_pkg::ST_DONE;
        end else begin
          r.status = sust_pkg::ST_NOT_FOUND;
        end
      end
      sust_pkg::CMD_FIND: begin
        r.status = hit ? sust_pkg::ST_FOUND : sust_pkg::ST_NOT_FOUND;
      end
      default: begin
        cnt      = 0;
        r.status = sust_pkg::ST_DONE;
      end
    endcase
    held_n  = cnt;
    r.count = 5'(cnt);
    pending_results.push_back(r);
  endfunction

  task automatic send_word(input sust_pkg::cmd_t cmd, input logic [31:0] value);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    apply_command(cmd, value);
  endtask

  task automatic test_extremes();
    send_word(sust_pkg::CMD_INSERT, VAL_MAX);
    send_word(sust_pkg::CMD_INSERT, VAL_MIN);
    send_word(sust_pkg::CMD_INSERT, 32'd0);
    send_word(sust_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_word(sust_pkg::CMD_FIND, VAL_MIN);
    send_word(sust_pkg::CMD_INSERT, 32'd0);
    send_word(sust_pkg::CMD_ERASE, 32'd5);
    send_word(sust_pkg::CMD_ERASE, 32'hFFFF_FFFF);
    send_word(sust_pkg::CMD_CLEAR, VAL_MAX);
  endtask

  task automatic test_full_table();
    int i;
    // descending order so every insert shifts the whole row
    for (i = 0; i < sust_pkg::CAPACITY; i++) begin
      send_word(sust_pkg::CMD_INSERT, 32'(800 - i * 100));
    end
    send_word(sust_pkg::CMD_INSERT, 32'd5);
    send_word(sust_pkg::CMD_INSERT, 32'd800);
  endtask

  function automatic logic [31:0] edge_value(input int k);
    case (k)
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return 32'd0;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'd1;
      5:       return VAL_MIN + 32'd1;
      default: return VAL_MAX - 32'd1;
    endcase
  endfunction

  function automatic void fill_pool();
    int i;
    pool_n = $urandom_range(4, 28);
    for (i = 0; i < pool_n; i++) begin
      case ($urandom_range(0, 3))
        0:       value_pool[i] = edge_value($urandom_range(0, 6));
        1:       value_pool[i] = 32'($urandom_range(0, 40)) - 32'd20;
        default: value_pool[i] = $urandom;
      endcase
    end
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return value_pool[$urandom_range(0, pool_n - 1)];
  endfunction

  task automatic test_random_traffic(input int n_items);
    int             sent;
    int             r;
    int             ins_w;
    int             era_w;
    sust_pkg::cmd_t cmd;
    sent = 0;
    while (sent < n_items) begin
      fill_pool();
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 2))
        0:       begin ins_w = 40; era_w = 25; end
        1:       begin ins_w = 65; era_w = 15; end
        default: begin ins_w = 25; era_w = 50; end
      endcase
      repeat (50) begin
        r = $urandom_range(0, 99);
        if (r < ins_w) cmd = sust_pkg::CMD_INSERT;
        else if (r < ins_w + era_w) cmd = sust_pkg::CMD_ERASE;
        else if (r < 98) cmd = sust_pkg::CMD_FIND;
        else cmd = sust_pkg::CMD_CLEAR;
        send_word(cmd, pick_value());
      end
      sent += 50;
    end
    no_idle = 1'b0;
  endtask

  // result side backpressure
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0 && !no_idle) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    set_result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[1:0] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_tdata[1:0]);
          mismatch_count++;
        end
        if (out_tdata[2] !== want.present) begin
          $display("%0t: present expected %0d actual %0d", $time, want.present,
                   out_tdata[2]);
          mismatch_count++;
        end
        if (out_tdata[7:3] !== want.rank) begin
          $display("%0t: rank expected %0d actual %0d", $time, want.rank,
                   out_tdata[7:3]);
          mismatch_count++;
        end
        if (out_tdata[12:8] !== want.count) begin
          $display("%0t: element_count expected %0d actual %0d", $time, want.count,
                   out_tdata[12:8]);
          mismatch_count++;
        end
        if (out_tdata[15:13] !== 3'b000) begin
          $display("%0t: padding expected 0 actual %0d", $time, out_tdata[15:13]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_full_table();
    test_random_traffic(950);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sorted_unique_set_table_top_tb OK");
    end else begin
      $display("sorted_unique_set_table_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("sorted_unique_set_table_top_tb NOT OK");
    $finish;
  end

endmodule
